FILE: design/mcwq_pkg.sv
package mcwq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    localparam int CMD_W   = 3;
    localparam int REQ_W   = 8;
    localparam int STAT_W  = 3;
    localparam int OUT_W   = 16;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    localparam logic [REQ_W-1:0] ID_MASK = REQ_W'((1 << ID_WIDTH) - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOCK        = 3'd0,
        CMD_UNLOCK      = 3'd1,
        CMD_UNLOCK_WAIT = 3'd2,
        CMD_COND_WAIT   = 3'd3,
        CMD_SIGNAL      = 3'd4,
        CMD_BROADCAST   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_ACQUIRED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_KEPT      = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_ALREADY   = 3'd5,
        ST_FULL      = 3'd6,
        ST_NONE      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_BMOVE,
        S_BREAD,
        S_DONE
    } t_state;

endpackage

FILE: design/mcwq_ram.sv
module mcwq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mutex_condition_wait_queues.sv
// Lock unit: one owner register, a FIFO of tasks waiting for the lock and a
// FIFO of tasks waiting on one condition variable.
// Input channel (s_axis): tuser carries the command (lock, unlock, unlock if
// waiters, condition wait, signal, broadcast), tdata the requesting task id.
// Output channel (m_axis): one result beat per command with the status, the
// task that was handed the lock (if any) and whether the lock is now held.
// Sequence: a command is taken in the idle state, the queue heads are read from
// the two queue RAMs in the next cycle, then the command executes and the
// result is loaded into the output register. A broadcast moves its waiters one
// after another; each move reads the new condition queue head through the
// registered RAM port, and one more pass finds the condition queue empty or the
// lock queue full.
// tready is high only in the idle state, one command at a time.
// A result waiting in the output register does not block the next command; a
// stalled receiver only holds the sequencer in its last state until the
// output register frees up.
// Reset (synchronous, active low) frees the lock and empties both queues; the
// queue RAMs are not cleared, only entries below each count are ever read.
module mutex_condition_wait_queues (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] requester
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [2:0] status, [3] woken_valid,
                                          // [11:4] woken_id, [12] lock_held
);

    localparam int PTR_W = mcwq_pkg::PTR_W;
    localparam int CNT_W = mcwq_pkg::CNT_W;
    localparam int SUM_W = mcwq_pkg::SUM_W;
    localparam int REQ_W = mcwq_pkg::REQ_W;

    // Sequencer and command registers
    mcwq_pkg::t_state  r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [REQ_W-1:0]  r_req, n_req;

    // Lock state
    logic              r_owner_valid, n_owner_valid;
    logic [REQ_W-1:0]  r_owner_id, n_owner_id;
    logic [PTR_W-1:0]  r_lq_head, n_lq_head;
    logic [CNT_W-1:0]  r_lq_count, n_lq_count;
    logic [PTR_W-1:0]  r_cq_head, n_cq_head;
    logic [CNT_W-1:0]  r_cq_count, n_cq_count;

    // Per-command result
    mcwq_pkg::t_status r_status, n_status;
    logic              r_woke, n_woke;
    logic [REQ_W-1:0]  r_woke_id, n_woke_id;
    logic              r_granted, n_granted;

    // Output register
    logic              r_out_valid, n_out_valid;
    mcwq_pkg::t_status r_out_status, n_out_status;
    logic              r_out_woke, n_out_woke;
    logic [REQ_W-1:0]  r_out_woke_id, n_out_woke_id;
    logic              r_out_held, n_out_held;

    // Queue RAM ports
    logic              lq_we, cq_we;
    logic [REQ_W-1:0]  lq_wdata, cq_wdata;
    logic [REQ_W-1:0]  lq_rdata, cq_rdata;
    logic [PTR_W-1:0]  lq_tail, cq_tail;
    logic [SUM_W-1:0]  lq_sum, cq_sum;
    logic [PTR_W-1:0]  lq_head_inc, cq_head_inc;

    logic              lq_full, cq_full, is_owner;
    logic              do_release, do_move;

    mcwq_ram #(
        .DEPTH(mcwq_pkg::QUEUE_DEPTH),
        .WIDTH(REQ_W)
    ) u_lock_q (
        .i_clk  (i_clk),
        .i_we   (lq_we),
        .i_waddr(lq_tail),
        .i_wdata(lq_wdata),
        .i_raddr(r_lq_head),
        .o_rdata(lq_rdata)
    );

    mcwq_ram #(
        .DEPTH(mcwq_pkg::QUEUE_DEPTH),
        .WIDTH(REQ_W)
    ) u_cond_q (
        .i_clk  (i_clk),
        .i_we   (cq_we),
        .i_waddr(cq_tail),
        .i_wdata(cq_wdata),
        .i_raddr(r_cq_head),
        .o_rdata(cq_rdata)
    );

    // Tail = head + count, wrapped into the ring
    assign lq_sum  = SUM_W'(r_lq_head) + SUM_W'(r_lq_count);
    assign cq_sum  = SUM_W'(r_cq_head) + SUM_W'(r_cq_count);
    assign lq_tail = (lq_sum >= SUM_W'(mcwq_pkg::QUEUE_DEPTH))
                   ? PTR_W'(lq_sum - SUM_W'(mcwq_pkg::QUEUE_DEPTH)) : PTR_W'(lq_sum);
    assign cq_tail = (cq_sum >= SUM_W'(mcwq_pkg::QUEUE_DEPTH))
                   ? PTR_W'(cq_sum - SUM_W'(mcwq_pkg::QUEUE_DEPTH)) : PTR_W'(cq_sum);

    assign lq_head_inc = (r_lq_head == PTR_W'(mcwq_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_lq_head + 1'b1;
    assign cq_head_inc = (r_cq_head == PTR_W'(mcwq_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_cq_head + 1'b1;

    assign lq_full  = (r_lq_count == CNT_W'(mcwq_pkg::QUEUE_DEPTH));
    assign cq_full  = (r_cq_count == CNT_W'(mcwq_pkg::QUEUE_DEPTH));
    assign is_owner = r_owner_valid && (r_owner_id == r_req);

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_req         = r_req;
        n_owner_valid = r_owner_valid;
        n_owner_id    = r_owner_id;
        n_lq_head     = r_lq_head;
        n_lq_count    = r_lq_count;
        n_cq_head     = r_cq_head;
        n_cq_count    = r_cq_count;
        n_status      = r_status;
        n_woke        = r_woke;
        n_woke_id     = r_woke_id;
        n_granted     = r_granted;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_woke    = r_out_woke;
        n_out_woke_id = r_out_woke_id;
        n_out_held    = r_out_held;
        lq_we         = 1'b0;
        lq_wdata      = r_req;
        cq_we         = 1'b0;
        cq_wdata      = r_req;
        do_release    = 1'b0;
        do_move       = 1'b0;
        o_s_axis_tready = 1'b0;

        // Drop the output beat once taken; a new load below overrides
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mcwq_pkg::S_IDLE: begin
                // hold off the sender while reset is asserted
                o_s_axis_tready = i_rst_n;
                if (i_s_axis_tvalid && i_rst_n) begin
                    n_cmd     = i_s_axis_tuser;
                    n_req     = i_s_axis_tdata & mcwq_pkg::ID_MASK;
                    n_woke    = 1'b0;
                    n_woke_id = '0;
                    n_granted = 1'b0;
                    n_state   = mcwq_pkg::S_READ;
                end
            end
            mcwq_pkg::S_READ: begin
                // queue heads are being read out of the RAMs
                n_state = mcwq_pkg::S_EXEC;
            end
            mcwq_pkg::S_EXEC: begin
                n_state = mcwq_pkg::S_DONE;
                unique case (r_cmd)
                    mcwq_pkg::CMD_LOCK: begin
                        if (is_owner) begin
                            n_status = mcwq_pkg::ST_ALREADY;
                        end else if (!r_owner_valid) begin
                            n_owner_valid = 1'b1;
                            n_owner_id    = r_req;
                            n_status      = mcwq_pkg::ST_ACQUIRED;
                        end else if (lq_full) begin
                            n_status = mcwq_pkg::ST_FULL;
                        end else begin
                            lq_we      = 1'b1;
                            lq_wdata   = r_req;
                            n_lq_count = r_lq_count + 1'b1;
                            n_status   = mcwq_pkg::ST_QUEUED;
                        end
                    end
                    mcwq_pkg::CMD_UNLOCK: begin
                        if (!is_owner) begin
                            n_status = mcwq_pkg::ST_NOT_OWNER;
                        end else begin
                            do_release = 1'b1;
                            n_status   = mcwq_pkg::ST_RELEASED;
                        end
                    end
                    mcwq_pkg::CMD_UNLOCK_WAIT: begin
                        if (!is_owner) begin
                            n_status = mcwq_pkg::ST_NOT_OWNER;
                        end else if (r_lq_count == '0) begin
                            n_status = mcwq_pkg::ST_KEPT;
                        end else begin
                            do_release = 1'b1;
                            n_status   = mcwq_pkg::ST_RELEASED;
                        end
                    end
                    mcwq_pkg::CMD_COND_WAIT: begin
                        if (!is_owner) begin
                            n_status = mcwq_pkg::ST_NOT_OWNER;
                        end else if (cq_full) begin
                            n_status = mcwq_pkg::ST_FULL;
                        end else begin
                            cq_we      = 1'b1;
                            cq_wdata   = r_req;
                            n_cq_count = r_cq_count + 1'b1;
                            do_release = 1'b1;
                            n_status   = mcwq_pkg::ST_QUEUED;
                        end
                    end
                    mcwq_pkg::CMD_SIGNAL: begin
                        if (r_cq_count == '0) begin
                            n_status = mcwq_pkg::ST_NONE;
                        end else if (r_owner_valid && lq_full) begin
                            n_status = mcwq_pkg::ST_FULL;
                        end else begin
                            do_move  = 1'b1;
                            n_status = r_owner_valid ? mcwq_pkg::ST_QUEUED
                                                     : mcwq_pkg::ST_ACQUIRED;
                        end
                    end
                    mcwq_pkg::CMD_BROADCAST: begin
                        if (r_cq_count == '0) begin
                            n_status = mcwq_pkg::ST_NONE;
                        end else begin
                            n_state = mcwq_pkg::S_BMOVE;
                        end
                    end
                    default: begin
                        n_status = mcwq_pkg::ST_KEPT;
                    end
                endcase
            end
            mcwq_pkg::S_BMOVE: begin
                // move one condition waiter per pass, head data is current
                if (r_cq_count == '0) begin
                    n_status = r_granted ? mcwq_pkg::ST_ACQUIRED : mcwq_pkg::ST_QUEUED;
                    n_state  = mcwq_pkg::S_DONE;
                end else if (r_owner_valid && lq_full) begin
                    n_status = mcwq_pkg::ST_FULL;
                    n_state  = mcwq_pkg::S_DONE;
                end else begin
                    do_move = 1'b1;
                    n_state = mcwq_pkg::S_BREAD;
                end
            end
            mcwq_pkg::S_BREAD: begin
                n_state = mcwq_pkg::S_BMOVE;
            end
            mcwq_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_woke    = r_woke;
                    n_out_woke_id = r_woke_id;
                    n_out_held    = r_owner_valid;
                    n_state       = mcwq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcwq_pkg::S_IDLE;
            end
        endcase

        // Release: hand the lock to the oldest lock waiter or free it
        if (do_release) begin
            if (r_lq_count != '0) begin
                n_owner_valid = 1'b1;
                n_owner_id    = lq_rdata;
                n_woke        = 1'b1;
                n_woke_id     = lq_rdata;
                n_lq_head     = lq_head_inc;
                n_lq_count    = r_lq_count - 1'b1;
            end else begin
                n_owner_valid = 1'b0;
            end
        end

        // Move the head condition waiter to the owner or the lock queue
        if (do_move) begin
            n_cq_head  = cq_head_inc;
            n_cq_count = r_cq_count - 1'b1;
            if (!r_owner_valid) begin
                n_owner_valid = 1'b1;
                n_owner_id    = cq_rdata;
                n_woke        = 1'b1;
                n_woke_id     = cq_rdata;
                n_granted     = 1'b1;
            end else begin
                lq_we      = 1'b1;
                lq_wdata   = cq_rdata;
                n_lq_count = r_lq_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mcwq_pkg::S_IDLE;
            r_owner_valid <= 1'b0;
            r_owner_id    <= '0;
            r_lq_head     <= '0;
            r_lq_count    <= '0;
            r_cq_head     <= '0;
            r_cq_count    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_owner_valid <= n_owner_valid;
            r_owner_id    <= n_owner_id;
            r_lq_head     <= n_lq_head;
            r_lq_count    <= n_lq_count;
            r_cq_head     <= n_cq_head;
            r_cq_count    <= n_cq_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_req         <= n_req;
        r_status      <= n_status;
        r_woke        <= n_woke;
        r_woke_id     <= n_woke_id;
        r_granted     <= n_granted;
        r_out_status  <= n_out_status;
        r_out_woke    <= n_out_woke;
        r_out_woke_id <= n_out_woke_id;
        r_out_held    <= n_out_held;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_held, r_out_woke_id, r_out_woke, r_out_status};

`ifndef NO_ASSERTIONS
    // queue counts never run past the ring size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lq_count <= CNT_W'(mcwq_pkg::QUEUE_DEPTH)) &&
        (r_cq_count <= CNT_W'(mcwq_pkg::QUEUE_DEPTH)))
        else $error("queue count out of range");

    // a free lock never leaves tasks waiting for it
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcwq_pkg::S_IDLE && !r_owner_valid) |-> (r_lq_count == '0))
        else $error("lock free while lock queue holds waiters");

    // a woken task always leaves the lock held
    a_woke_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_woke) |-> r_out_held)
        else $error("woken task reported with lock free");

    // an accepted command always starts with the head read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == mcwq_pkg::S_READ))
        else $error("accepted command did not start");
`endif

endmodule
